[design/crc_pkg.sv]
// Shared types, constants and helper functions for the circle and ray intersection core.
// Used by every module in the design folder; depends on nothing.
package crc_pkg;

    // Angle format of the bearing inputs and the Q30 format used inside the rotator
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int ANG_SHIFT       = 30 - ANGLE_FRAC_BITS;
    localparam int CORDIC_STEPS    = 30;
    localparam int SQRT_STEPS      = 31;

    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

    localparam logic signed [33:0] ATAN_HEAD [10] = '{
        34'sd843314857, 34'sd497837830, 34'sd263043837, 34'sd133525159, 34'sd67021687,
        34'sd33543516,  34'sd16775850,  34'sd8388438,   34'sd4194283,   34'sd2097149
    };

    // Per-transaction data that rides along the whole pipeline
    typedef struct packed {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic [30:0]        r;
        logic [31:0]        ct;
        logic [31:0]        lt;
        logic signed [15:0] br;
        logic signed [15:0] mb;
    } t_side;

    // Sideband through the rotator cells
    typedef struct packed {
        t_side              side;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic               neg;
    } t_cside;

    // Sideband through the square root cells
    typedef struct packed {
        t_side              side;
        logic signed [32:0] co;
        logic signed [32:0] si;
        logic signed [36:0] p;
        logic               miss;
        logic               tang;
    } t_sq_side;

    // Both candidate points of one transaction, ordered, with keep flags
    typedef struct packed {
        logic signed [31:0] x0;
        logic signed [31:0] y0;
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic               k0;
        logic               k1;
        logic signed [15:0] ang;
        logic [30:0]        r;
        logic [31:0]        ct;
        logic [31:0]        lt;
    } t_cand;

    // Rotation angle of one rotator step, Q30 radians
    function automatic logic signed [33:0] f_atan(input logic [4:0] step);
        logic signed [33:0] v;
        if (step < 5'd10) begin
            v = ATAN_HEAD[step[3:0]];
        end else begin
            v = 34'sd1 <<< (5'd30 - step);
        end
        return v;
    endfunction

    // Clamp a point coordinate to the signed 32-bit range
    function automatic logic signed [31:0] f_sat32(input logic signed [41:0] v);
        logic signed [31:0] s;
        if (v > 42'sd2147483647) begin
            s = 32'sh7FFFFFFF;
        end else if (v < -42'sd2147483648) begin
            s = 32'sh80000000;
        end else begin
            s = v[31:0];
        end
        return s;
    endfunction

endpackage

[design/crc_cordic_cell.sv]
// One rotation step of the sine and cosine rotator, registered.
// Depends on crc_pkg for the sideband type and the arctangent table.
module crc_cordic_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic [4:0]         i_step,
    input  logic               i_valid,
    input  logic signed [32:0] i_x,
    input  logic signed [32:0] i_y,
    input  logic signed [33:0] i_a,
    input  crc_pkg::t_cside    i_cs,
    output logic               o_valid,
    output logic signed [32:0] o_x,
    output logic signed [32:0] o_y,
    output logic signed [33:0] o_a,
    output crc_pkg::t_cside    o_cs
);
    import crc_pkg::*;

    logic signed [32:0] x_sh, y_sh, n_x, n_y;
    logic signed [33:0] at, n_a;
    logic               r_valid;
    logic signed [32:0] r_x, r_y;
    logic signed [33:0] r_a;
    t_cside             r_cs;

    // Rotate towards zero residual angle
    always_comb begin
        x_sh = i_x >>> i_step;
        y_sh = i_y >>> i_step;
        at   = f_atan(i_step);
        if (!i_a[33]) begin
            n_x = i_x - y_sh;
            n_y = i_y + x_sh;
            n_a = i_a - at;
        end else begin
            n_x = i_x + y_sh;
            n_y = i_y - x_sh;
            n_a = i_a + at;
        end
    end

    // Advance the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    // Hand the payload to the next cell
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_x  <= n_x;
            r_y  <= n_y;
            r_a  <= n_a;
            r_cs <= i_cs;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_a     = r_a;
    assign o_cs    = r_cs;
endmodule

[design/crc_sqrt_cell.sv]
// One digit step of the floor square root, registered.
// Depends on crc_pkg for the sideband type.
module crc_sqrt_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic [4:0]         i_step,
    input  logic               i_valid,
    input  logic [62:0]        i_v,
    input  logic [62:0]        i_res,
    input  crc_pkg::t_sq_side  i_sq,
    output logic               o_valid,
    output logic [62:0]        o_v,
    output logic [62:0]        o_res,
    output crc_pkg::t_sq_side  o_sq
);
    import crc_pkg::*;

    logic [62:0] bitv, trial, n_v, n_res;
    logic        r_valid;
    logic [62:0] r_v, r_res;
    t_sq_side    r_sq;

    // Try the next root bit and keep it when the remainder allows
    always_comb begin
        bitv  = 63'd1 << {5'd30 - i_step, 1'b0};
        trial = i_res + bitv;
        if (i_v >= trial) begin
            n_v   = i_v - trial;
            n_res = (i_res >> 1) + bitv;
        end else begin
            n_v   = i_v;
            n_res = i_res >> 1;
        end
    end

    // Advance the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    // Hand the payload to the next cell
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_v   <= n_v;
            r_res <= n_res;
            r_sq  <= i_sq;
        end
    end

    assign o_valid = r_valid;
    assign o_v     = r_v;
    assign o_res   = r_res;
    assign o_sq    = r_sq;
endmodule

[design/crc_result.sv]
// Output stage: turns one transaction's candidates into one or two results.
// Depends on crc_pkg for the candidate type.
module crc_result (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  crc_pkg::t_cand     i_cand,
    input  logic               i_stall,
    output logic               o_ready,
    output logic               o_valid,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic [30:0]        o_radius_out,
    output logic signed [15:0] o_angle_out,
    output logic [31:0]        o_time_of_circle,
    output logic [31:0]        o_time_of_line,
    output logic               o_found,
    output logic               o_last_point
);
    import crc_pkg::*;

    logic               r_valid, r_pend, r_found, r_last;
    logic signed [31:0] r_px, r_py, r_x1, r_y1;
    logic signed [15:0] r_ang;
    logic [30:0]        r_r;
    logic [31:0]        r_ct, r_lt;
    logic               load;

    // Take a new transaction when empty or when the last result leaves
    assign o_ready = !r_valid || (!i_stall && !r_pend);
    assign load    = i_valid && o_ready;

    // Control: valid and pending second result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_pend  <= i_cand.k0 && i_cand.k1;
        end else if (r_valid && !i_stall) begin
            r_valid <= r_pend;
            r_pend  <= 1'b0;
        end
    end

    // Payload: first result on load, second one after the first is taken
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_r  <= i_cand.r;
            r_ct <= i_cand.ct;
            r_lt <= i_cand.lt;
            r_x1 <= i_cand.x1;
            r_y1 <= i_cand.y1;
            if (i_cand.k0) begin
                r_px    <= i_cand.x0;
                r_py    <= i_cand.y0;
                r_ang   <= i_cand.ang;
                r_found <= 1'b1;
                r_last  <= !i_cand.k1;
            end else if (i_cand.k1) begin
                r_px    <= i_cand.x1;
                r_py    <= i_cand.y1;
                r_ang   <= i_cand.ang;
                r_found <= 1'b1;
                r_last  <= 1'b1;
            end else begin
                r_px    <= '0;
                r_py    <= '0;
                r_ang   <= '0;
                r_found <= 1'b0;
                r_last  <= 1'b1;
            end
        end else if (r_valid && !i_stall && r_pend) begin
            r_px   <= r_x1;
            r_py   <= r_y1;
            r_last <= 1'b1;
        end
    end

    assign o_valid          = r_valid;
    assign o_point_x        = r_px;
    assign o_point_y        = r_py;
    assign o_radius_out     = r_r;
    assign o_angle_out      = r_ang;
    assign o_time_of_circle = r_ct;
    assign o_time_of_line   = r_lt;
    assign o_found          = r_found;
    assign o_last_point     = r_last;
endmodule

[design/circle_ray_intersection_core.sv]
// Top level of the circle and ray intersection core: angle reduction, rotator cells,
// projection, square root cells and point arithmetic. Depends on crc_pkg and all crc_ modules.
//
//  channel | direction | handshake         | payload
//  input   | in        | i_valid / o_stall | circle, radius, times, origin, bearings
//  result  | out       | o_valid / i_stall | point, radius, angle, times, found, last
//
// The path from input to result holds 68 register stages; the pipeline takes one transaction
// per cycle while the result channel is not stalled, and the result register emits one result
// per cycle, so a transaction with two points holds every stage while its second result is sent.
// The whole pipeline advances together; a stalled result holds every stage.
// Reset is synchronous, active low, and clears only the valid and pending flags.
module circle_ray_intersection_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_circle_x,
    input  logic signed [31:0] i_circle_y,
    input  logic [30:0]        i_radius,
    input  logic [31:0]        i_circle_time,
    input  logic signed [31:0] i_origin_x,
    input  logic signed [31:0] i_origin_y,
    input  logic signed [15:0] i_bearing,
    input  logic [31:0]        i_line_time,
    input  logic signed [15:0] i_measured_bearing,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic [30:0]        o_radius_out,
    output logic signed [15:0] o_angle_out,
    output logic [31:0]        o_time_of_circle,
    output logic [31:0]        o_time_of_line,
    output logic               o_found,
    output logic               o_last_point
);
    import crc_pkg::*;

    logic adv;

    // Entry stage: angle reduction and offsets
    logic signed [35:0] a_w, a_r, a_f;
    logic               neg_w;
    t_cside             cs_w;
    logic               r0_valid;
    logic signed [33:0] r0_a;
    t_cside             r0_cs;

    always_comb begin
        a_w = 36'(i_bearing) <<< ANG_SHIFT;
        if (a_w > PI_Q30) begin
            a_r = a_w - TWO_PI_Q30;
        end else if (a_w <= -PI_Q30) begin
            a_r = a_w + TWO_PI_Q30;
        end else begin
            a_r = a_w;
        end
        if (a_r > HALF_PI_Q30) begin
            a_f   = a_r - PI_Q30;
            neg_w = 1'b1;
        end else if (a_r < -HALF_PI_Q30) begin
            a_f   = a_r + PI_Q30;
            neg_w = 1'b1;
        end else begin
            a_f   = a_r;
            neg_w = 1'b0;
        end
        cs_w.side.ox = i_origin_x;
        cs_w.side.oy = i_origin_y;
        cs_w.side.r  = i_radius;
        cs_w.side.ct = i_circle_time;
        cs_w.side.lt = i_line_time;
        cs_w.side.br = i_bearing;
        cs_w.side.mb = i_measured_bearing;
        cs_w.dx      = 33'(i_origin_x) - 33'(i_circle_x);
        cs_w.dy      = 33'(i_origin_y) - 33'(i_circle_y);
        cs_w.neg     = neg_w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (adv) begin
            r0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r0_a  <= a_f[33:0];
            r0_cs <= cs_w;
        end
    end

    // Rotator cells
    logic               c_valid [CORDIC_STEPS+1];
    logic signed [32:0] c_x     [CORDIC_STEPS+1];
    logic signed [32:0] c_y     [CORDIC_STEPS+1];
    logic signed [33:0] c_a     [CORDIC_STEPS+1];
    t_cside             c_cs    [CORDIC_STEPS+1];

    assign c_valid[0] = r0_valid;
    assign c_x[0]     = CORDIC_GAIN;
    assign c_y[0]     = '0;
    assign c_a[0]     = r0_a;
    assign c_cs[0]    = r0_cs;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        crc_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_step  (5'(k)),
            .i_valid (c_valid[k]),
            .i_x     (c_x[k]),
            .i_y     (c_y[k]),
            .i_a     (c_a[k]),
            .i_cs    (c_cs[k]),
            .o_valid (c_valid[k+1]),
            .o_x     (c_x[k+1]),
            .o_y     (c_y[k+1]),
            .o_a     (c_a[k+1]),
            .o_cs    (c_cs[k+1])
        );
    end

    // Projection products of the offset onto the ray direction
    logic signed [32:0] co_w, si_w;
    logic               r1_valid;
    logic signed [65:0] r1_pcx, r1_psy, r1_pcy, r1_psx;
    logic signed [32:0] r1_co, r1_si;
    t_side              r1_side;

    assign co_w = c_cs[CORDIC_STEPS].neg ? -c_x[CORDIC_STEPS] : c_x[CORDIC_STEPS];
    assign si_w = c_cs[CORDIC_STEPS].neg ? -c_y[CORDIC_STEPS] : c_y[CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (adv) begin
            r1_valid <= c_valid[CORDIC_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_pcx  <= co_w * c_cs[CORDIC_STEPS].dx;
            r1_psy  <= si_w * c_cs[CORDIC_STEPS].dy;
            r1_pcy  <= co_w * c_cs[CORDIC_STEPS].dy;
            r1_psx  <= si_w * c_cs[CORDIC_STEPS].dx;
            r1_co   <= co_w;
            r1_si   <= si_w;
            r1_side <= c_cs[CORDIC_STEPS].side;
        end
    end

    // Along-ray offset, perpendicular distance and miss test
    logic signed [36:0] p_w, h_w;
    logic [36:0]        ah_w;
    logic               r2_valid, r2_miss;
    logic signed [36:0] r2_p;
    logic [30:0]        r2_ah;
    logic signed [32:0] r2_co, r2_si;
    t_side              r2_side;

    always_comb begin
        p_w  = 37'(r1_pcx >>> 30) + 37'(r1_psy >>> 30);
        h_w  = 37'(r1_pcy >>> 30) - 37'(r1_psx >>> 30);
        ah_w = h_w[36] ? 37'(-h_w) : 37'(h_w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (adv) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_p    <= p_w;
            r2_ah   <= ah_w[30:0];
            r2_miss <= ah_w > 37'(r1_side.r);
            r2_co   <= r1_co;
            r2_si   <= r1_si;
            r2_side <= r1_side;
        end
    end

    // Squares of radius and distance
    logic               r3_valid, r3_miss;
    logic [61:0]        r3_rr, r3_hh;
    logic signed [36:0] r3_p;
    logic signed [32:0] r3_co, r3_si;
    t_side              r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (adv) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_rr   <= r2_side.r * r2_side.r;
            r3_hh   <= r2_ah * r2_ah;
            r3_miss <= r2_miss;
            r3_p    <= r2_p;
            r3_co   <= r2_co;
            r3_si   <= r2_si;
            r3_side <= r2_side;
        end
    end

    // Remainder under the root and tangent test
    logic [61:0] rem_w;
    logic        r4_valid;
    logic [61:0] r4_rem;
    t_sq_side    r4_sq;

    assign rem_w = r3_rr - r3_hh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (adv) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_rem        <= rem_w;
            r4_sq.side    <= r3_side;
            r4_sq.co      <= r3_co;
            r4_sq.si      <= r3_si;
            r4_sq.p       <= r3_p;
            r4_sq.miss    <= r3_miss;
            r4_sq.tang    <= rem_w == '0;
        end
    end

    // Square root cells
    logic        q_valid [SQRT_STEPS+1];
    logic [62:0] q_v     [SQRT_STEPS+1];
    logic [62:0] q_res   [SQRT_STEPS+1];
    t_sq_side    q_sq    [SQRT_STEPS+1];

    assign q_valid[0] = r4_valid;
    assign q_v[0]     = {1'b0, r4_rem};
    assign q_res[0]   = '0;
    assign q_sq[0]    = r4_sq;

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        crc_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_step  (5'(k)),
            .i_valid (q_valid[k]),
            .i_v     (q_v[k]),
            .i_res   (q_res[k]),
            .i_sq    (q_sq[k]),
            .o_valid (q_valid[k+1]),
            .o_v     (q_v[k+1]),
            .o_res   (q_res[k+1]),
            .o_sq    (q_sq[k+1])
        );
    end

    // Ray parameters of both roots and their products with the direction
    t_sq_side           sq_e;
    logic signed [37:0] np_w, s_w, tc0_w, tc1_w;
    logic               r5_valid, r5_two, r5_one;
    logic signed [37:0] r5_tc0, r5_tc1;
    logic signed [70:0] r5_m0x, r5_m0y, r5_m1x, r5_m1y;
    logic signed [15:0] r5_ang;
    t_side              r5_side;

    always_comb begin
        sq_e  = q_sq[SQRT_STEPS];
        np_w  = -38'(sq_e.p);
        s_w   = 38'(q_res[SQRT_STEPS][30:0]);
        tc0_w = sq_e.tang ? np_w : np_w + s_w;
        tc1_w = np_w - s_w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (adv) begin
            r5_valid <= q_valid[SQRT_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_m0x  <= tc0_w * sq_e.co;
            r5_m0y  <= tc0_w * sq_e.si;
            r5_m1x  <= tc1_w * sq_e.co;
            r5_m1y  <= tc1_w * sq_e.si;
            r5_tc0  <= tc0_w;
            r5_tc1  <= tc1_w;
            r5_one  <= !sq_e.miss;
            r5_two  <= !sq_e.miss && !sq_e.tang;
            r5_ang  <= sq_e.tang ? sq_e.side.br : sq_e.side.mb;
            r5_side <= sq_e.side;
        end
    end

    // Points, larger x first, and the forward test
    logic signed [41:0] xs0, ys0, xs1, ys1;
    logic signed [37:0] t0, t1;
    logic               swap;
    t_cand              cand;

    always_comb begin
        xs0  = 42'(r5_side.ox) + 42'(r5_m0x >>> 30);
        ys0  = 42'(r5_side.oy) + 42'(r5_m0y >>> 30);
        xs1  = 42'(r5_side.ox) + 42'(r5_m1x >>> 30);
        ys1  = 42'(r5_side.oy) + 42'(r5_m1y >>> 30);
        swap = r5_two && (xs1 > xs0);
        t0   = swap ? r5_tc1 : r5_tc0;
        t1   = swap ? r5_tc0 : r5_tc1;
        cand.x0  = f_sat32(swap ? xs1 : xs0);
        cand.y0  = f_sat32(swap ? ys1 : ys0);
        cand.x1  = f_sat32(swap ? xs0 : xs1);
        cand.y1  = f_sat32(swap ? ys0 : ys1);
        cand.k0  = r5_one && !t0[37] && (t0 != '0);
        cand.k1  = r5_two && !t1[37] && (t1 != '0);
        cand.ang = r5_ang;
        cand.r   = r5_side.r;
        cand.ct  = r5_side.ct;
        cand.lt  = r5_side.lt;
    end

    // Result register and channel
    crc_result u_result (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (r5_valid),
        .i_cand           (cand),
        .i_stall          (i_stall),
        .o_ready          (adv),
        .o_valid          (o_valid),
        .o_point_x        (o_point_x),
        .o_point_y        (o_point_y),
        .o_radius_out     (o_radius_out),
        .o_angle_out      (o_angle_out),
        .o_time_of_circle (o_time_of_circle),
        .o_time_of_line   (o_time_of_line),
        .o_found          (o_found),
        .o_last_point     (o_last_point)
    );

    assign o_stall = !adv;
endmodule

[bench/tb_circle_ray_intersection_core.sv]
// Self-checking testbench for circle_ray_intersection_core: a bit-exact predictor of the
// forward line/circle intersection, a queue-fed driver and a result monitor.
// Depends on crc_pkg and the design sources.
module tb_circle_ray_intersection_core;
    timeunit 1ns;
    timeprecision 1ps;
    import crc_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic signed [31:0] cx, cy, ox, oy;
        logic [30:0]        r;
        logic [31:0]        ct, lt;
        logic signed [15:0] br, mb;
    } meas_t;

    typedef struct {
        logic signed [31:0] x, y;
        logic [30:0]        r;
        logic signed [15:0] ang;
        logic [31:0]        ct, lt;
        logic               found, last;
    } point_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [31:0] i_circle_x = '0, i_circle_y = '0, i_origin_x = '0, i_origin_y = '0;
    logic [30:0]        i_radius = '0;
    logic [31:0]        i_circle_time = '0, i_line_time = '0;
    logic signed [15:0] i_bearing = '0, i_measured_bearing = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_point_x, o_point_y;
    logic [30:0]        o_radius_out;
    logic signed [15:0] o_angle_out;
    logic [31:0]        o_time_of_circle, o_time_of_line;
    logic               o_found, o_last_point;

    meas_t  pending_meas[$];
    point_t expected_points[$];
    int     n_accepted = 0, n_results = 0, n_found = 0, n_tangent = 0, n_mismatch = 0;
    int     n_cycles = 0;
    bit     stimulus_done = 0;

    circle_ray_intersection_core DUT (.*);

    always #5 i_clk = ~i_clk;

    // Rotator: sine and cosine of a Q2.13 bearing, Q30
    function automatic void bearing_trig(input logic signed [15:0] ang,
                                         output longint co, output longint si);
        longint a, x, y, nx, at;
        bit     neg;
        a = longint'(ang) * (64'sd1 <<< ANG_SHIFT);
        x = CORDIC_GAIN;
        y = 0;
        neg = 0;
        while (a > PI_Q30) a -= TWO_PI_Q30;
        while (a <= -PI_Q30) a += TWO_PI_Q30;
        if (a > HALF_PI_Q30) begin
            a -= PI_Q30;
            neg = 1;
        end else if (a < -HALF_PI_Q30) begin
            a += PI_Q30;
            neg = 1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            at = (i < 10) ? longint'(ATAN_HEAD[i]) : (64'sd1 <<< (30 - i));
            if (a >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                a -= at;
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                a += at;
            end
            x = nx;
        end
        co = neg ? -x : x;
        si = neg ? -y : y;
    endfunction

    // Perpendicular offset of the circle centre from the line
    function automatic wide_t perp_offset(input meas_t m);
        longint co, si;
        wide_t  dx, dy;
        bearing_trig(m.br, co, si);
        dx = wide_t'(m.ox) - wide_t'(m.cx);
        dy = wide_t'(m.oy) - wide_t'(m.cy);
        return ((wide_t'(co) * dy) >>> 30) - ((wide_t'(si) * dx) >>> 30);
    endfunction

    function automatic logic signed [31:0] clamp32(input wide_t v);
        if (v > wide_t'(64'sd2147483647)) return 32'sh7FFFFFFF;
        if (v < -wide_t'(64'sd2147483648)) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Work out the results of one measurement and queue them
    task automatic predict_points(input meas_t m);
        longint          co, si;
        wide_t           dx, dy, p, h, tc[2], xs[2], ys[2], t;
        longint unsigned ah, rem;
        int              nc, n;
        logic signed [15:0] ang;
        point_t          pt;
        bearing_trig(m.br, co, si);
        dx = wide_t'(m.ox) - wide_t'(m.cx);
        dy = wide_t'(m.oy) - wide_t'(m.cy);
        p = ((wide_t'(co) * dx) >>> 30) + ((wide_t'(si) * dy) >>> 30);
        h = ((wide_t'(co) * dy) >>> 30) - ((wide_t'(si) * dx) >>> 30);
        nc = 0;
        n = 0;
        ang = '0;
        if ((h < 0 ? -h : h) <= wide_t'(m.r)) begin
            ah = longint'(h < 0 ? -h : h);
            rem = longint'(m.r) * longint'(m.r) - ah * ah;
            if (rem == 0) begin
                tc[0] = -p;
                nc = 1;
                ang = m.br;
                n_tangent++;
            end else begin
                tc[0] = -p + wide_t'(floor_root(rem));
                tc[1] = -p - wide_t'(floor_root(rem));
                nc = 2;
                ang = m.mb;
            end
        end
        for (int i = 0; i < nc; i++) begin
            xs[i] = wide_t'(m.ox) + ((tc[i] * wide_t'(co)) >>> 30);
            ys[i] = wide_t'(m.oy) + ((tc[i] * wide_t'(si)) >>> 30);
        end
        // Larger x first; on equal x the larger t stays in front
        if (nc == 2 && xs[1] > xs[0]) begin
            t = tc[0]; tc[0] = tc[1]; tc[1] = t;
            t = xs[0]; xs[0] = xs[1]; xs[1] = t;
            t = ys[0]; ys[0] = ys[1]; ys[1] = t;
        end
        pt.r = m.r;
        pt.ct = m.ct;
        pt.lt = m.lt;
        for (int i = 0; i < nc; i++) begin
            if (tc[i] > 0) begin
                pt.x = clamp32(xs[i]);
                pt.y = clamp32(ys[i]);
                pt.ang = ang;
                pt.found = 1'b1;
                pt.last = 1'b0;
                expected_points.push_back(pt);
                n++;
            end
        end
        if (n == 0) begin
            pt.x = '0;
            pt.y = '0;
            pt.ang = '0;
            pt.found = 1'b0;
            pt.last = 1'b0;
            expected_points.push_back(pt);
        end
        expected_points[$].last = 1'b1;
    endtask

    function automatic meas_t rand_meas();
        meas_t m;
        m.cx = $urandom;
        m.cy = $urandom;
        m.ox = $urandom;
        m.oy = $urandom;
        m.r  = $urandom;
        m.ct = $urandom;
        m.lt = $urandom;
        m.br = $urandom;
        m.mb = $urandom;
        return m;
    endfunction

    // Circle placed close to the origin so the line mostly hits it
    function automatic meas_t near_meas(input int spread);
        meas_t m;
        m = rand_meas();
        m.ox = $signed($urandom_range(0, 2 * spread)) - spread;
        m.oy = $signed($urandom_range(0, 2 * spread)) - spread;
        m.cx = m.ox + $signed($urandom_range(0, 2 * spread)) - spread;
        m.cy = m.oy + $signed($urandom_range(0, 2 * spread)) - spread;
        m.r  = $urandom_range(1, 2 * spread);
        return m;
    endfunction

    // Same geometry with the radius set to touch the line exactly
    function automatic meas_t touch_meas(input meas_t m);
        wide_t h;
        h = perp_offset(m);
        if (h < 0) h = -h;
        if (h <= wide_t'(32'h7FFFFFFF)) m.r = h[30:0];
        return m;
    endfunction

    function automatic meas_t directed_meas(input int k);
        meas_t m;
        m = near_meas(32'h0010_0000);
        case (k)
            0: m.r = '0;
            1: m.r = 31'h7FFFFFFF;
            2: begin
                m.cx = 32'sh7FFFFFFF; m.cy = 32'sh80000000;
                m.ox = 32'sh80000000; m.oy = 32'sh7FFFFFFF;
            end
            3: begin
                m.cx = 32'sh80000000; m.cy = 32'sh7FFFFFFF;
                m.ox = 32'sh7FFFFFFF; m.oy = 32'sh80000000; m.r = 31'h7FFFFFFF;
            end
            4: m.br = 16'sh7FFF;
            5: m.br = 16'sh8000;
            6: m.br = 16'sd0;
            7: m.br = 16'sd12868;          // about +pi/2, near-vertical ray
            8: m.br = -16'sd12868;
            9: m.br = 16'sd25736;          // about pi
            10: begin                      // miss: centre far off the line
                m.br = 16'sd0; m.ox = 0; m.oy = 0; m.cx = 0;
                m.cy = 32'sh0100_0000; m.r = 31'h0001_0000;
            end
            11: begin                      // circle fully behind the origin
                m.br = 16'sd0; m.ox = 0; m.oy = 0;
                m.cx = -32'sh0100_0000; m.cy = 0; m.r = 31'h0001_0000;
            end
            12: begin                      // origin inside: one root ahead
                m.br = 16'sd0; m.ox = 0; m.oy = 0; m.cx = 0; m.cy = 0;
                m.r = 31'h0005_0000;
            end
            13, 14, 15: m = touch_meas(m);
            16: begin
                m.ct = '0; m.lt = '1; m.mb = 16'sh8000;
            end
            17: begin
                m.ct = '1; m.lt = '0; m.mb = 16'sh7FFF;
            end
            default: m = rand_meas();
        endcase
        return m;
    endfunction

    // Input driver
    always @(posedge i_clk) begin
        meas_t m;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) n_accepted++;
            if (!i_valid || !o_stall) begin
                if (pending_meas.size() > 0 &&
                    ((n_accepted > 250 && n_accepted < 400) || $urandom_range(0, 99) >= 8)) begin
                    m = pending_meas.pop_front();
                    predict_points(m);
                    i_valid            <= 1'b1;
                    i_circle_x         <= m.cx;
                    i_circle_y         <= m.cy;
                    i_radius           <= m.r;
                    i_circle_time      <= m.ct;
                    i_origin_x         <= m.ox;
                    i_origin_y         <= m.oy;
                    i_bearing          <= m.br;
                    i_line_time        <= m.lt;
                    i_measured_bearing <= m.mb;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and back-pressure
    always @(posedge i_clk) begin
        point_t e;
        n_cycles++;
        if (i_rst_n) begin
            i_stall <= (n_results > 300 && n_results < 600) ? 1'b0 : ($urandom_range(0, 99) < 8);
            if (o_valid && !i_stall) begin
                n_results++;
                if (o_found) n_found++;
                if (expected_points.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) $display("unexpected result x=%0d y=%0d", o_point_x, o_point_y);
                end else begin
                    e = expected_points.pop_front();
                    if (o_point_x !== e.x || o_point_y !== e.y || o_radius_out !== e.r ||
                        o_angle_out !== e.ang || o_time_of_circle !== e.ct ||
                        o_time_of_line !== e.lt || o_found !== e.found ||
                        o_last_point !== e.last) begin
                        n_mismatch++;
                        if (n_mismatch <= 10) begin
                            $display("mismatch at result %0d:", n_results);
                            $display("  exp x=%0d y=%0d r=%0d ang=%0d ct=%h lt=%h found=%b last=%b",
                                     e.x, e.y, e.r, e.ang, e.ct, e.lt, e.found, e.last);
                            $display("  got x=%0d y=%0d r=%0d ang=%0d ct=%h lt=%h found=%b last=%b",
                                     o_point_x, o_point_y, o_radius_out, o_angle_out,
                                     o_time_of_circle, o_time_of_line, o_found, o_last_point);
                        end
                    end
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin
        int k;
        for (k = 0; k < 20; k++) pending_meas.push_back(directed_meas(k));
        for (k = 0; k < 630; k++) begin
            case ($urandom_range(0, 9))
                0, 1: pending_meas.push_back(rand_meas());
                2: pending_meas.push_back(touch_meas(near_meas($urandom_range(1, 32'h0100_0000))));
                3: pending_meas.push_back(near_meas(32'h3FFF_FFFF));
                default: pending_meas.push_back(near_meas($urandom_range(1, 32'h0100_0000)));
            endcase
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_meas.size() == 0 && !i_valid);
        wait (expected_points.size() == 0);
        repeat (100) @(posedge i_clk);
        if (expected_points.size() != 0) n_mismatch++;
        $display("Ran %0d measurements: %0d results, %0d points found, %0d tangent cases.",
                 n_accepted, n_results, n_found, n_tangent);
        if (n_mismatch == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", n_mismatch);
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Timeout
    initial begin
        #2ms;
        $display("timeout after %0d cycles", n_cycles);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[files.f]
design/crc_pkg.sv
design/crc_cordic_cell.sv
design/crc_sqrt_cell.sv
design/crc_result.sv
design/circle_ray_intersection_core.sv
bench/tb_circle_ray_intersection_core.sv
